// ===== hdl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg: shared types and constants for the 64-bit primality tester
// Small-prime table, witness table, controller commands, states and status.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int NUM_SMALL = 12;
  localparam int NUM_BASES = 7;

  localparam logic [5:0] SMALL_PRIMES [0:NUM_SMALL-1] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  localparam logic [63:0] MR_BASES [0:NUM_BASES-1] = '{
    64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504, 64'd1795265022
  };

  localparam logic [2:0] LAST_BASE = 3'(NUM_BASES - 1);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,        // capture candidate, d = n-1, reset lanes and counters
    CMD_TRIAL_STEP,  // one bit of trial division on all lanes
    CMD_SPLIT_STEP,  // d >>= 1, s++
    CMD_BASE_LOAD,   // clear base remainder, bit counter to top
    CMD_BASE_STEP,   // one bit of base mod n
    CMD_BASE_NEXT,   // advance witness index
    CMD_EXP_INIT,    // x = 1, exponent index to top
    CMD_EXP_NEXT,    // exponent index down
    CMD_MUL_SQ,      // start x*x mod n
    CMD_MUL_A,       // start x*a mod n
    CMD_MUL_STEP,    // one half-step of shift-and-add
    CMD_MUL_STORE,   // x = product
    CMD_RND_INIT,    // r = 1
    CMD_RND_STORE    // x = product, r++
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic n_lt2;
    logic small_prime;
    logic small_factor;
    logic d_odd;
    logic a_zero;
    logic exp_bit;
    logic mul_last;
    logic x_one;
    logic x_nm1;
    logic r_done;
    logic last_base;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TRIAL,
    S_SMALL,
    S_SPLIT,
    S_BASE_LD,
    S_BASE_MOD,
    S_BASE_CHK,
    S_SQ,
    S_SQ_RUN,
    S_SQ_ST,
    S_ML,
    S_ML_RUN,
    S_ML_ST,
    S_EXP_NX,
    S_EXP_CHK,
    S_RND,
    S_RND_RUN,
    S_RND_ST,
    S_RND_CHK,
    S_NEXT_BASE,
    S_FIN
  } state_t;

endpackage

// ===== hdl/mrpt_if.sv =====
// ----------------------------------------------------------------------------
// mrpt_if: valid/ready channels of the primality tester
// Candidate channel and verdict channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface mrpt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== hdl/miller_rabin_prime_test_64.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64: deterministic 64-bit primality tester
// Trial division by primes to 37, then strong-probable-prime tests on seven
// fixed witnesses; exact for every 64-bit candidate.
// ----------------------------------------------------------------------------
// Usage:
//  in_ch  (sink)  : valid/ready transfer of one 64-bit candidate.
//  out_ch (source): valid/ready transfer of one is_prime bit per candidate.
//  One candidate is processed at a time. in_ch.ready is high only while the
//  sequencer is idle; a finished verdict sits in the output register, so the
//  next candidate is taken while that verdict still waits for out_ch.ready.
// Operation:
//  Trial division walks n one bit per cycle over twelve lanes. Small values
//  and small factors are answered straight after the trial pass. Otherwise
//  each modular product is shift-and-add with one modular add per cycle.
//  Exponentiation scans all 64 bits of d (a square, plus a multiply on each
//  set bit); each witness then adds at most s-1 extra squarings, and s plus
//  the set bits of d never exceed 64. Up to seven witnesses run. The modular
//  adder sets the pace.
// Reset: rst_n (synchronous, active low) returns the sequencer to idle and
//  drops out_ch.valid. If the receiver stalls, the verdict holds and the
//  sequencer waits in its final state once the next one is ready.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64 (
  input  logic       clk,
  input  logic       rst_n,
  mrpt_in_if.sink    in_ch,
  mrpt_out_if.source out_ch
);

  mrpt_pkg::cmd_t    cmd;
  mrpt_pkg::status_t status;
  logic idle, res_load, res_val, in_fire, out_free;
  logic out_valid_r, out_valid_nxt;
  logic is_prime_r, is_prime_nxt;

  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;
  // output slot is free when empty or being drained this cycle
  assign out_free    = !out_valid_r || out_ch.ready;

  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle),
    .res_load (res_load),
    .res_val  (res_val)
  );

  mrpt_dp u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .cand   (in_ch.candidate),
    .status (status)
  );

  // verdict output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    is_prime_nxt  = is_prime_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
      is_prime_nxt  = res_val;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    is_prime_r <= is_prime_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_prime = is_prime_r;

  // a verdict only overwrites an empty or draining slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("verdict loaded over a pending transfer");

  // after a candidate transfer the tester is busy for at least the trial pass
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!in_ch.ready ##1 !in_ch.ready))
    else $error("input ready too soon after transfer");

  // no verdict can come out right after a candidate is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !res_load)
    else $error("verdict produced without processing");

endmodule

// ===== hdl/mrpt_dp.sv =====
// ----------------------------------------------------------------------------
// mrpt_dp: primality tester datapath
// Trial-division lanes, n-1 split, base reduction and modular multiplier.
// ----------------------------------------------------------------------------
module mrpt_dp (
  input  logic                 clk,
  input  mrpt_pkg::cmd_t       cmd,
  input  logic [63:0]          cand,
  output mrpt_pkg::status_t    status
);

  logic [63:0] n_r, d_r, a_r, x_r, mx_r, my_r, acc_r;
  logic [5:0]  s_r, r_r, cnt_r, mbit_r;
  logic        mph_r;
  logic [2:0]  bidx_r;
  logic [5:0]  rem_r [0:mrpt_pkg::NUM_SMALL-1];
  logic [5:0]  rem_nxt [0:mrpt_pkg::NUM_SMALL-1];

  logic [63:0] nm1;
  logic [63:0] acc_dbl, acc_add;
  logic [64:0] base_t;
  logic [63:0] base_nxt;
  logic        sp_hit, sf_hit;

  function automatic logic [63:0] add_mod(input logic [63:0] p, input logic [63:0] q,
                                          input logic [63:0] m);
    logic [64:0] sum;
    sum = {1'b0, p} + {1'b0, q};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[63:0];
  endfunction

  assign nm1     = n_r - 64'd1;
  assign acc_dbl = add_mod(acc_r, acc_r, n_r);
  assign acc_add = add_mod(acc_r, mx_r, n_r);

  // one restoring-division bit of the current witness mod n
  always_comb begin
    base_t = {a_r, mrpt_pkg::MR_BASES[bidx_r][cnt_r]};
    if (base_t >= {1'b0, n_r}) begin
      base_t = base_t - {1'b0, n_r};
    end
    base_nxt = base_t[63:0];
  end

  // trial-division lanes, one bit of n per step
  always_comb begin
    logic [6:0] t;
    sp_hit = 1'b0;
    sf_hit = 1'b0;
    for (int i = 0; i < mrpt_pkg::NUM_SMALL; i++) begin
      t = {rem_r[i], n_r[cnt_r]};
      if (t >= {1'b0, mrpt_pkg::SMALL_PRIMES[i]}) begin
        t = t - {1'b0, mrpt_pkg::SMALL_PRIMES[i]};
      end
      rem_nxt[i] = t[5:0];
      if (n_r == {58'd0, mrpt_pkg::SMALL_PRIMES[i]}) sp_hit = 1'b1;
      if (rem_r[i] == 6'd0) sf_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      mrpt_pkg::CMD_LOAD: begin
        n_r    <= cand;
        d_r    <= cand - 64'd1;
        s_r    <= 6'd0;
        cnt_r  <= 6'd63;
        bidx_r <= 3'd0;
        for (int i = 0; i < mrpt_pkg::NUM_SMALL; i++) rem_r[i] <= 6'd0;
      end
      mrpt_pkg::CMD_TRIAL_STEP: begin
        for (int i = 0; i < mrpt_pkg::NUM_SMALL; i++) rem_r[i] <= rem_nxt[i];
        cnt_r <= cnt_r - 6'd1;
      end
      mrpt_pkg::CMD_SPLIT_STEP: begin
        d_r <= {1'b0, d_r[63:1]};
        s_r <= s_r + 6'd1;
      end
      mrpt_pkg::CMD_BASE_LOAD: begin
        a_r   <= 64'd0;
        cnt_r <= 6'd63;
      end
      mrpt_pkg::CMD_BASE_STEP: begin
        a_r   <= base_nxt;
        cnt_r <= cnt_r - 6'd1;
      end
      mrpt_pkg::CMD_BASE_NEXT: bidx_r <= bidx_r + 3'd1;
      mrpt_pkg::CMD_EXP_INIT: begin
        x_r   <= 64'd1;
        cnt_r <= 6'd63;
      end
      mrpt_pkg::CMD_EXP_NEXT: cnt_r <= cnt_r - 6'd1;
      mrpt_pkg::CMD_MUL_SQ, mrpt_pkg::CMD_MUL_A: begin
        mx_r   <= x_r;
        my_r   <= (cmd == mrpt_pkg::CMD_MUL_SQ) ? x_r : a_r;
        acc_r  <= 64'd0;
        mbit_r <= 6'd63;
        mph_r  <= 1'b0;
      end
      mrpt_pkg::CMD_MUL_STEP: begin
        if (!mph_r) begin
          acc_r <= acc_dbl;
          mph_r <= 1'b1;
        end else begin
          if (my_r[mbit_r]) acc_r <= acc_add;
          mbit_r <= mbit_r - 6'd1;
          mph_r  <= 1'b0;
        end
      end
      mrpt_pkg::CMD_MUL_STORE: x_r <= acc_r;
      mrpt_pkg::CMD_RND_INIT:  r_r <= 6'd1;
      mrpt_pkg::CMD_RND_STORE: begin
        x_r <= acc_r;
        r_r <= r_r + 6'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.cnt_zero     = (cnt_r == 6'd0);
    status.n_lt2        = (n_r[63:1] == 63'd0);
    status.small_prime  = sp_hit;
    status.small_factor = sf_hit;
    status.d_odd        = d_r[0];
    status.a_zero       = (a_r == 64'd0);
    status.exp_bit      = d_r[cnt_r];
    status.mul_last     = mph_r && (mbit_r == 6'd0);
    status.x_one        = (x_r == 64'd1);
    status.x_nm1        = (x_r == nm1);
    status.r_done       = (r_r >= s_r);
    status.last_base    = (bidx_r == mrpt_pkg::LAST_BASE);
  end

endmodule

// ===== hdl/mrpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrpt_ctrl: primality tester sequencer
// Steps trial division, split, base reduction, exponentiation and rounds.
// ----------------------------------------------------------------------------
module mrpt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_free,
  input  mrpt_pkg::status_t  status,
  output mrpt_pkg::cmd_t     cmd,
  output logic               idle,
  output logic               res_load,
  output logic               res_val
);

  mrpt_pkg::state_t state_r, state_nxt;
  logic verdict_r, verdict_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mrpt_pkg::S_IDLE;
      verdict_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      verdict_r <= verdict_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    verdict_nxt = verdict_r;
    unique case (state_r)
      mrpt_pkg::S_IDLE:     if (in_fire) state_nxt = mrpt_pkg::S_TRIAL;
      mrpt_pkg::S_TRIAL:    if (status.cnt_zero) state_nxt = mrpt_pkg::S_SMALL;
      mrpt_pkg::S_SMALL: begin
        priority if (status.n_lt2) begin
          verdict_nxt = 1'b0;
          state_nxt   = mrpt_pkg::S_FIN;
        end else if (status.small_prime) begin
          verdict_nxt = 1'b1;
          state_nxt   = mrpt_pkg::S_FIN;
        end else if (status.small_factor) begin
          verdict_nxt = 1'b0;
          state_nxt   = mrpt_pkg::S_FIN;
        end else begin
          state_nxt = mrpt_pkg::S_SPLIT;
        end
      end
      mrpt_pkg::S_SPLIT:    if (status.d_odd) state_nxt = mrpt_pkg::S_BASE_LD;
      mrpt_pkg::S_BASE_LD:  state_nxt = mrpt_pkg::S_BASE_MOD;
      mrpt_pkg::S_BASE_MOD: if (status.cnt_zero) state_nxt = mrpt_pkg::S_BASE_CHK;
      mrpt_pkg::S_BASE_CHK: state_nxt = status.a_zero ? mrpt_pkg::S_NEXT_BASE : mrpt_pkg::S_SQ;
      mrpt_pkg::S_SQ:       state_nxt = mrpt_pkg::S_SQ_RUN;
      mrpt_pkg::S_SQ_RUN:   if (status.mul_last) state_nxt = mrpt_pkg::S_SQ_ST;
      mrpt_pkg::S_SQ_ST:    state_nxt = status.exp_bit ? mrpt_pkg::S_ML : mrpt_pkg::S_EXP_NX;
      mrpt_pkg::S_ML:       state_nxt = mrpt_pkg::S_ML_RUN;
      mrpt_pkg::S_ML_RUN:   if (status.mul_last) state_nxt = mrpt_pkg::S_ML_ST;
      mrpt_pkg::S_ML_ST:    state_nxt = mrpt_pkg::S_EXP_NX;
      mrpt_pkg::S_EXP_NX:
        state_nxt = status.cnt_zero ? mrpt_pkg::S_EXP_CHK : mrpt_pkg::S_SQ;
      mrpt_pkg::S_EXP_CHK:
        state_nxt = (status.x_one || status.x_nm1) ? mrpt_pkg::S_NEXT_BASE : mrpt_pkg::S_RND;
      mrpt_pkg::S_RND: begin
        if (status.r_done) begin
          verdict_nxt = 1'b0;
          state_nxt   = mrpt_pkg::S_FIN;
        end else begin
          state_nxt = mrpt_pkg::S_RND_RUN;
        end
      end
      mrpt_pkg::S_RND_RUN:  if (status.mul_last) state_nxt = mrpt_pkg::S_RND_ST;
      mrpt_pkg::S_RND_ST:   state_nxt = mrpt_pkg::S_RND_CHK;
      mrpt_pkg::S_RND_CHK:
        state_nxt = status.x_nm1 ? mrpt_pkg::S_NEXT_BASE : mrpt_pkg::S_RND;
      mrpt_pkg::S_NEXT_BASE: begin
        if (status.last_base) begin
          verdict_nxt = 1'b1;
          state_nxt   = mrpt_pkg::S_FIN;
        end else begin
          state_nxt = mrpt_pkg::S_BASE_LD;
        end
      end
      mrpt_pkg::S_FIN:      if (out_free) state_nxt = mrpt_pkg::S_IDLE;
      default:              state_nxt = mrpt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = mrpt_pkg::CMD_NONE;
    idle     = 1'b0;
    res_load = 1'b0;
    res_val  = verdict_r;
    unique case (state_r)
      mrpt_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_fire) cmd = mrpt_pkg::CMD_LOAD;
      end
      mrpt_pkg::S_TRIAL:    cmd = mrpt_pkg::CMD_TRIAL_STEP;
      mrpt_pkg::S_SPLIT:    if (!status.d_odd) cmd = mrpt_pkg::CMD_SPLIT_STEP;
      mrpt_pkg::S_BASE_LD:  cmd = mrpt_pkg::CMD_BASE_LOAD;
      mrpt_pkg::S_BASE_MOD: cmd = mrpt_pkg::CMD_BASE_STEP;
      mrpt_pkg::S_BASE_CHK: if (!status.a_zero) cmd = mrpt_pkg::CMD_EXP_INIT;
      mrpt_pkg::S_SQ:       cmd = mrpt_pkg::CMD_MUL_SQ;
      mrpt_pkg::S_ML:       cmd = mrpt_pkg::CMD_MUL_A;
      mrpt_pkg::S_SQ_RUN, mrpt_pkg::S_ML_RUN, mrpt_pkg::S_RND_RUN:
        cmd = mrpt_pkg::CMD_MUL_STEP;
      mrpt_pkg::S_SQ_ST, mrpt_pkg::S_ML_ST: cmd = mrpt_pkg::CMD_MUL_STORE;
      mrpt_pkg::S_EXP_NX:   if (!status.cnt_zero) cmd = mrpt_pkg::CMD_EXP_NEXT;
      mrpt_pkg::S_EXP_CHK:
        if (!(status.x_one || status.x_nm1)) cmd = mrpt_pkg::CMD_RND_INIT;
      mrpt_pkg::S_RND:      if (!status.r_done) cmd = mrpt_pkg::CMD_MUL_SQ;
      mrpt_pkg::S_RND_ST:   cmd = mrpt_pkg::CMD_RND_STORE;
      mrpt_pkg::S_NEXT_BASE: if (!status.last_base) cmd = mrpt_pkg::CMD_BASE_NEXT;
      mrpt_pkg::S_FIN:      res_load = out_free;
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_miller_rabin_prime_test_64.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_prime_test_64: self-checking bench for the primality tester
// Drives candidates through the input channel and compares each verdict
// against an in-bench square-and-multiply primality predictor.
// ----------------------------------------------------------------------------
module tb_miller_rabin_prime_test_64;

  localparam int  MAX_SHOWN  = 10;
  // sized for 100 worst-case primes plus stall slack, several times over
  localparam longint CYCLE_LIMIT = 64'd120_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mrpt_in_if  cand_ch ();
  mrpt_out_if verdict_ch ();

  miller_rabin_prime_test_64 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cand_ch.sink),
    .out_ch (verdict_ch.source)
  );

  // expected verdicts, oldest first
  logic   verdict_q [$];
  int     mismatches = 0;
  int     orphans    = 0;
  int     sent       = 0;
  int     checked    = 0;
  int     primes_seen = 0;
  longint cycles     = 0;
  bit     hold_off   = 1'b0;  // long receiver stall while the sender keeps going
  bit     rx_idle_on = 1'b1;

  // --------------------------------------------------------------------------
  // predictor: exact modular arithmetic on 128-bit products
  // --------------------------------------------------------------------------
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                         logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e,
                                         logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, b, m);
      b = mulmod(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic predict_prime(logic [63:0] n);
    logic [63:0] d, a, x;
    int s;
    bit comp;
    if (n < 2) return 1'b0;
    for (int i = 0; i < mrpt_pkg::NUM_SMALL; i++) begin
      if (n == 64'(mrpt_pkg::SMALL_PRIMES[i])) return 1'b1;
      if (n % 64'(mrpt_pkg::SMALL_PRIMES[i]) == 0) return 1'b0;
    end
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    for (int i = 0; i < mrpt_pkg::NUM_BASES; i++) begin
      a = mrpt_pkg::MR_BASES[i] % n;
      if (a == 0) continue;  // witness is a multiple of n
      x = powmod(a, d, n);
      if (x == 1 || x == n - 1) continue;
      comp = 1'b1;
      for (int r = 1; r < s; r++) begin
        x = mulmod(x, x, n);
        if (x == n - 1) begin
          comp = 1'b0;
          break;
        end
      end
      if (comp) return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // sender: one transfer, driven on the falling edge, accepted at rising
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_candidate(logic [63:0] n);
    int gap;
    @(negedge clk);
    // gap between bursts
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        cand_ch.valid     <= 1'b0;
        cand_ch.candidate <= 64'(~n);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    cand_ch.candidate <= n;
    cand_ch.valid     <= 1'b1;
    do @(posedge clk); while (!cand_ch.ready);
    verdict_q.push_back(predict_prime(n));
    sent++;
  endtask

  // --------------------------------------------------------------------------
  // receiver: stalls on its own pattern, checks each verdict transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || hold_off)
      verdict_ch.ready <= 1'b0;
    else if (!rx_idle_on)
      verdict_ch.ready <= 1'b1;
    else
      verdict_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst_n && verdict_ch.valid && verdict_ch.ready) begin
      if (verdict_q.size() == 0) begin
        orphans++;
        $display("ERROR: verdict %0b with nothing expected", verdict_ch.is_prime);
      end else begin
        logic want;
        want = verdict_q.pop_front();
        checked++;
        if (want) primes_seen++;
        if (verdict_ch.is_prime !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("ERROR: verdict #%0d expected %0b got %0b",
                     checked, want, verdict_ch.is_prime);
        end
      end
    end
  end

  // receiver mode toggles between a stall pattern and always-ready stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 2999) == 0) rx_idle_on <= ~rx_idle_on;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // helpers for stimulus
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_odd(int bits);
    logic [63:0] v;
    v = rand64();
    if (bits < 64) v = v & ((64'd1 << bits) - 1);
    return v | 64'd1;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_edges();
    send_candidate(64'd0);
    send_candidate(64'd1);
    send_candidate(64'd2);
    send_candidate(64'd37);
    send_candidate(64'd41);                      // first prime past the table
    send_candidate(64'd4);
    send_candidate(64'd74);                      // 2*37
    send_candidate(64'd1369);                    // 37^2, small factor
    send_candidate(64'hFFFF_FFFF_FFFF_FFFF);     // max, composite
    send_candidate(64'hFFFF_FFFF_FFFF_FFC5);     // largest 64-bit prime
    send_candidate(64'hFFFF_FFFF_FFFF_FFFE);
    send_candidate(64'hAAAA_AAAA_AAAA_AAAA);
    send_candidate(64'h5555_5555_5555_5555);
  endtask

  task automatic test_small_primes();
    for (int i = 0; i < mrpt_pkg::NUM_SMALL; i++)
      send_candidate(64'(mrpt_pkg::SMALL_PRIMES[i]));
  endtask

  task automatic test_special();
    send_candidate(64'd163);          // base reduces mod n
    send_candidate(64'd5 * 5 * 13);   // 325 itself is composite w/ small factor
    send_candidate(64'd1795265022 + 1);
    send_candidate(64'd3215031751);   // strong pseudoprime to small bases
    send_candidate(64'd2047);         // spsp base 2
    send_candidate(64'd1_000_000_007);
    send_candidate(64'd4294967297);   // 2^32+1 = 641*6700417
  endtask

  task automatic test_random(int count);
    logic [63:0] n;
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0:       n = rand64();
        1, 2:    n = rand_odd($urandom_range(6, 16));   // small, often prime
        3:       n = rand_odd(64) | 64'h8000_0000_0000_0000;
        4:       n = 64'($urandom_range(0, 2000));
        5:       n = 64'(mrpt_pkg::SMALL_PRIMES[$urandom_range(0, mrpt_pkg::NUM_SMALL-1)])
                     * rand_odd(20);
        default: n = rand_odd($urandom_range(17, 40));
      endcase
      send_candidate(n);
    end
  endtask

  // receiver holds off for a long while; sender keeps offering quick items
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        // even values settle in trial division, so the output fills fast
        for (int k = 0; k < 4; k++)
          send_candidate(64'($urandom_range(0, 500)) << 1);
      end
    join
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    cand_ch.valid     = 1'b0;
    cand_ch.candidate = 64'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edges();
    test_small_primes();
    test_special();
    test_backpressure();
    test_random(64);

    @(negedge clk);
    cand_ch.valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d candidates, %0d verdicts checked, %0d primes",
             sent, checked, primes_seen);
    if (mismatches == 0 && orphans == 0 && verdict_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("mismatches %0d, unexpected %0d", mismatches, orphans);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/mrpt_pkg.sv
hdl/mrpt_if.sv
hdl/mrpt_dp.sv
hdl/mrpt_ctrl.sv
hdl/miller_rabin_prime_test_64.sv
tb/tb_miller_rabin_prime_test_64.sv
